[src/rcm_pkg.sv]
// Shared types, codes and widths of the RCM graph ordering block.
package rcm_pkg;

   localparam int DEF_MAX_NODES    = 1024;
   localparam int DEF_MAX_NONZEROS = 8192;
   localparam int DEF_MAX_DEGREE   = 64;

   localparam int VALUE_W = 14;
   localparam int NODE_W  = 10;
   localparam int CFG_W   = 11;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   typedef enum logic [1:0] {
      OP_ROW  = 2'd0,
      OP_COL  = 2'd1,
      OP_RUN  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_BAD = 2'd1,
      ST_OVF = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      CMD_NONE,
      CMD_LOAD_ROW,
      CMD_LOAD_COL,
      CMD_READ,
      CMD_READ_DONE,
      CMD_RUN_START,
      CMD_RV_RD,
      CMD_RV_EV,
      CMD_CK_START,
      CMD_K_RD,
      CMD_K_INC,
      CMD_W_INIT,
      CMD_S_INIT,
      CMD_S_RD,
      CMD_S_EV,
      CMD_S_END,
      CMD_Q_RD,
      CMD_Q_POP,
      CMD_Q_END,
      CMD_Q_BEG,
      CMD_N_VRD,
      CMD_N_EV,
      CMD_A_ONE,
      CMD_A_ZERO,
      CMD_A_RD,
      CMD_SO_X,
      CMD_SO_CMP,
      CMD_SO_SH,
      CMD_SO_PUT,
      CMD_P_WR,
      CMD_END_OK,
      CMD_END_BAD,
      CMD_END_OVF
   } cmd_type;

   typedef struct packed {
      logic bad_init;
      logic i_done;
      logic row_bad;
      logic k_at_prev;
      logic k_at_end;
      logic col_bad;
      logic q_empty;
      logic fill_zero;
      logic vis_set;
      logic cnt_full;
      logic a_done;
      logic push_done;
      logic b_zero;
      logic shift;
   } dp_status_type;

endpackage

[src/rcm_if.sv]
// Request and response word channels of the RCM graph ordering block.
interface rcm_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [rcm_pkg::VALUE_W-1:0]  value;
   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface rcm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcm_pkg::NODE_W-1:0]   node;
   logic [1:0]                   status;
   modport source (output valid, output node, output status, input ready);
   modport sink   (input valid, input node, input status, output ready);
endinterface

[src/rcm_datapath.sv]
// Datapath of the RCM ordering: pattern stores, walk memories, counters.
module rcm_datapath #(
   parameter int MAX_NODES    = rcm_pkg::DEF_MAX_NODES,
   parameter int MAX_NONZEROS = rcm_pkg::DEF_MAX_NONZEROS,
   parameter int MAX_DEGREE   = rcm_pkg::DEF_MAX_DEGREE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rcm_pkg::cmd_type              cmd,
   input  logic [rcm_pkg::VALUE_W-1:0]   req_value,
   input  logic [rcm_pkg::CFG_W-1:0]     node_count,
   output rcm_pkg::dp_status_type        stat,
   output logic [rcm_pkg::NODE_W-1:0]    rsp_node,
   output rcm_pkg::status_type           rsp_status
);
   localparam int VW  = rcm_pkg::VALUE_W;
   localparam int IW  = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int CAW = $clog2(MAX_NONZEROS);
   localparam int CCW = $clog2(MAX_NONZEROS + 1);
   localparam int DAW = $clog2(MAX_DEGREE);
   localparam int DCW = $clog2(MAX_DEGREE + 1);
   localparam int NBW = VW + IW;

   logic [VW-1:0]  row_mem [MAX_NODES];
   logic [VW-1:0]  col_mem [MAX_NONZEROS];
   logic [VW-1:0]  deg_mem [MAX_NODES];
   logic           vis_mem [MAX_NODES];
   logic [IW-1:0]  ord_mem [MAX_NODES];
   logic [IW-1:0]  q_mem   [MAX_NODES];
   logic [NBW-1:0] nb_mem  [MAX_DEGREE];

   logic [VW-1:0]  row_rd_ff, col_rd_ff, deg_rd_ff;
   logic           vis_rd_ff;
   logic [IW-1:0]  ord_rd_ff, q_rd_ff;
   logic [NBW-1:0] nb_rd_ff;

   logic           row_we, col_we, deg_we, vis_we, ord_we, q_we, nb_we;
   logic [IW-1:0]  row_wa, row_ra, deg_wa, vis_wa, vis_ra, ord_wa, ord_ra, q_wa, q_ra;
   logic [CAW-1:0] col_wa, col_ra;
   logic [DAW-1:0] nb_wa, nb_ra;
   logic [VW-1:0]  row_wd, col_wd, deg_wd;
   logic           vis_wd;
   logic [IW-1:0]  ord_wd, q_wd;
   logic [NBW-1:0] nb_wd;

   logic [NCW-1:0] rows_ff, rows_in, i_ff, i_in, qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [NCW-1:0] fill_ff, fill_in, rbase;
   logic [CCW-1:0] cols_ff, cols_in, k_ff, k_in, cbase;
   logic           reload_ff, reload_in, found_ff, found_in;
   rcm_pkg::status_type run_status_ff, run_status_in, rsp_status_ff, rsp_status_in;
   logic [rcm_pkg::CFG_W-1:0] ordered_ff, ordered_in;
   logic [VW-1:0]  prev_ff, prev_in, kend_ff, kend_in, best_ff, best_in;
   logic [IW-1:0]  u_ff, u_in, v_ff, v_in, start_ff, start_in;
   logic [DCW-1:0] cnt_ff, cnt_in, a_ff, a_in, b_ff, b_in;
   logic [NBW-1:0] x_ff, x_in;
   logic [rcm_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;

   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      row_rd_ff <= row_mem[row_ra];
   end
   always_ff @(posedge clock) begin
      if (col_we) col_mem[col_wa] <= col_wd;
      col_rd_ff <= col_mem[col_ra];
   end
   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      deg_rd_ff <= deg_mem[vis_ra];
   end
   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[vis_ra];
   end
   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_wa] <= ord_wd;
      ord_rd_ff <= ord_mem[ord_ra];
   end
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wa] <= q_wd;
      q_rd_ff <= q_mem[q_ra];
   end
   always_ff @(posedge clock) begin
      if (nb_we) nb_mem[nb_wa] <= nb_wd;
      nb_rd_ff <= nb_mem[nb_ra];
   end

   always_comb begin
      stat.bad_init  = (node_count == '0) || (32'(node_count) > MAX_NODES) ||
                       (32'(rows_ff) < 32'(node_count));
      stat.i_done    = 32'(i_ff) == 32'(node_count);
      stat.row_bad   = (row_rd_ff < prev_ff) || (32'(row_rd_ff) > 32'(cols_ff));
      stat.k_at_prev = 32'(k_ff) == 32'(prev_ff);
      stat.k_at_end  = 32'(k_ff) == 32'(kend_ff);
      stat.col_bad   = 32'(col_rd_ff) >= 32'(node_count);
      stat.q_empty   = qhead_ff == qtail_ff;
      stat.fill_zero = fill_ff == '0;
      stat.vis_set   = vis_rd_ff;
      stat.cnt_full  = 32'(cnt_ff) >= MAX_DEGREE;
      stat.a_done    = a_ff >= cnt_ff;
      stat.push_done = (a_ff >= cnt_ff) || (32'(qtail_ff) >= MAX_NODES);
      stat.b_zero    = b_ff == '0;
      stat.shift     = nb_rd_ff[NBW-1:IW] > x_ff[NBW-1:IW];
   end

   always_comb begin
      rbase = reload_ff ? '0 : rows_ff;
      cbase = reload_ff ? '0 : cols_ff;

      row_we = 1'b0; row_wa = IW'(rbase); row_wd = req_value; row_ra = IW'(i_ff);
      col_we = 1'b0; col_wa = CAW'(cbase); col_wd = req_value; col_ra = CAW'(k_ff);
      deg_we = 1'b0; deg_wa = IW'(i_ff); deg_wd = row_rd_ff - prev_ff;
      vis_we = 1'b0; vis_wa = IW'(i_ff); vis_wd = 1'b0; vis_ra = IW'(i_ff);
      ord_we = 1'b0; ord_wa = IW'(fill_ff - 1'b1); ord_wd = q_rd_ff; ord_ra = IW'(req_value);
      q_we   = 1'b0; q_wa = IW'(qtail_ff); q_wd = start_ff; q_ra = IW'(qhead_ff);
      nb_we  = 1'b0; nb_wa = DAW'(cnt_ff); nb_wd = {deg_rd_ff, v_ff}; nb_ra = DAW'(a_ff);

      rows_in = rows_ff; cols_in = cols_ff; reload_in = reload_ff;
      run_status_in = run_status_ff; ordered_in = ordered_ff;
      i_in = i_ff; prev_in = prev_ff; k_in = k_ff; kend_in = kend_ff;
      qhead_in = qhead_ff; qtail_in = qtail_ff; fill_in = fill_ff;
      u_in = u_ff; v_in = v_ff; cnt_in = cnt_ff; a_in = a_ff; b_in = b_ff; x_in = x_ff;
      best_in = best_ff; start_in = start_ff; found_in = found_ff;
      rsp_node_in = rsp_node_ff; rsp_status_in = rsp_status_ff;

      case (cmd)
         rcm_pkg::CMD_LOAD_ROW: begin
            reload_in = 1'b0;
            cols_in   = cbase;
            row_we    = 32'(rbase) < MAX_NODES;
            rows_in   = row_we ? rbase + 1'b1 : rbase;
         end
         rcm_pkg::CMD_LOAD_COL: begin
            reload_in = 1'b0;
            rows_in   = rbase;
            col_we    = 32'(cbase) < MAX_NONZEROS;
            cols_in   = col_we ? cbase + 1'b1 : cbase;
         end
         rcm_pkg::CMD_READ: begin
            if (run_status_ff != rcm_pkg::ST_OK)
               rsp_status_in = run_status_ff;
            else if ((32'(req_value) >= 32'(ordered_ff)) || (32'(req_value) >= MAX_NODES))
               rsp_status_in = rcm_pkg::ST_BAD;
            else
               rsp_status_in = rcm_pkg::ST_OK;
         end
         rcm_pkg::CMD_READ_DONE: begin
            rsp_node_in = (rsp_status_ff == rcm_pkg::ST_OK) ?
                          rcm_pkg::NODE_W'(ord_rd_ff) : '0;
         end
         rcm_pkg::CMD_RUN_START: begin
            i_in = '0; prev_in = '0;
         end
         rcm_pkg::CMD_RV_RD: ;
         rcm_pkg::CMD_RV_EV: begin
            deg_we = 1'b1; vis_we = 1'b1; vis_wd = 1'b0;
            prev_in = row_rd_ff; i_in = i_ff + 1'b1;
         end
         rcm_pkg::CMD_CK_START: k_in = '0;
         rcm_pkg::CMD_K_RD: ;
         rcm_pkg::CMD_K_INC: k_in = k_ff + 1'b1;
         rcm_pkg::CMD_W_INIT: begin
            qhead_in = '0; qtail_in = '0; fill_in = NCW'(node_count);
         end
         rcm_pkg::CMD_S_INIT: begin
            i_in = '0; found_in = 1'b0;
         end
         rcm_pkg::CMD_S_RD: ;
         rcm_pkg::CMD_S_EV: begin
            if (!vis_rd_ff && (!found_ff || deg_rd_ff < best_ff)) begin
               best_in = deg_rd_ff; start_in = IW'(i_ff); found_in = 1'b1;
            end
            i_in = i_ff + 1'b1;
         end
         rcm_pkg::CMD_S_END: begin
            vis_we = 1'b1; vis_wa = start_ff; vis_wd = 1'b1;
            q_we = 1'b1; qtail_in = qtail_ff + 1'b1;
         end
         rcm_pkg::CMD_Q_RD: qhead_in = qhead_ff + 1'b1;
         rcm_pkg::CMD_Q_POP: begin
            u_in = q_rd_ff; fill_in = fill_ff - 1'b1; ord_we = 1'b1; row_ra = q_rd_ff;
         end
         rcm_pkg::CMD_Q_END: begin
            kend_in = row_rd_ff; row_ra = u_ff - 1'b1;
         end
         rcm_pkg::CMD_Q_BEG: begin
            k_in = (u_ff == '0) ? '0 : CCW'(row_rd_ff); cnt_in = '0;
         end
         rcm_pkg::CMD_N_VRD: begin
            v_in = IW'(col_rd_ff); vis_ra = IW'(col_rd_ff);
         end
         rcm_pkg::CMD_N_EV: begin
            if (!vis_rd_ff) begin
               nb_we = 1'b1; vis_we = 1'b1; vis_wa = v_ff; vis_wd = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         rcm_pkg::CMD_A_ONE:  a_in = DCW'(1);
         rcm_pkg::CMD_A_ZERO: a_in = '0;
         rcm_pkg::CMD_A_RD: ;
         rcm_pkg::CMD_SO_X: begin
            x_in = nb_rd_ff; b_in = a_ff;
         end
         rcm_pkg::CMD_SO_CMP: nb_ra = DAW'(b_ff - 1'b1);
         rcm_pkg::CMD_SO_SH: begin
            nb_we = 1'b1; nb_wa = DAW'(b_ff); nb_wd = nb_rd_ff; b_in = b_ff - 1'b1;
         end
         rcm_pkg::CMD_SO_PUT: begin
            nb_we = 1'b1; nb_wa = DAW'(b_ff); nb_wd = x_ff; a_in = a_ff + 1'b1;
         end
         rcm_pkg::CMD_P_WR: begin
            q_we = 1'b1; q_wd = nb_rd_ff[IW-1:0];
            qtail_in = qtail_ff + 1'b1; a_in = a_ff + 1'b1;
         end
         rcm_pkg::CMD_END_OK, rcm_pkg::CMD_END_BAD, rcm_pkg::CMD_END_OVF: begin
            case (cmd)
               rcm_pkg::CMD_END_OK:  run_status_in = rcm_pkg::ST_OK;
               rcm_pkg::CMD_END_BAD: run_status_in = rcm_pkg::ST_BAD;
               default:              run_status_in = rcm_pkg::ST_OVF;
            endcase
            ordered_in    = node_count;
            reload_in     = 1'b1;
            rsp_node_in   = '0;
            rsp_status_in = run_status_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= '0;
         cols_ff       <= '0;
         reload_ff     <= 1'b0;
         run_status_ff <= rcm_pkg::ST_OK;
         ordered_ff    <= '0;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         reload_ff     <= reload_in;
         run_status_ff <= run_status_in;
         ordered_ff    <= ordered_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; prev_ff <= prev_in; k_ff <= k_in; kend_ff <= kend_in;
      qhead_ff <= qhead_in; qtail_ff <= qtail_in; fill_ff <= fill_in;
      u_ff <= u_in; v_ff <= v_in; cnt_ff <= cnt_in; a_ff <= a_in; b_ff <= b_in;
      x_ff <= x_in; best_ff <= best_in; start_ff <= start_in; found_ff <= found_in;
      rsp_node_ff <= rsp_node_in; rsp_status_ff <= rsp_status_in;
   end

   assign rsp_node   = rsp_node_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[src/rcm_controller.sv]
// Sequencer of the RCM ordering: handshakes and the step order of a run.
module rcm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  rcm_pkg::op_type        req_op,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rcm_pkg::dp_status_type stat,
   output rcm_pkg::cmd_type       cmd
);
   typedef enum logic [24:0] {
      S_IDLE    = 25'b1 << 0,
      S_RD_WAIT = 25'b1 << 1,
      S_RV_RD   = 25'b1 << 2,
      S_RV_EV   = 25'b1 << 3,
      S_CK_RD   = 25'b1 << 4,
      S_CK_EV   = 25'b1 << 5,
      S_S_INIT  = 25'b1 << 6,
      S_S_RD    = 25'b1 << 7,
      S_S_EV    = 25'b1 << 8,
      S_S_END   = 25'b1 << 9,
      S_Q_CHK   = 25'b1 << 10,
      S_Q_POP   = 25'b1 << 11,
      S_Q_END   = 25'b1 << 12,
      S_Q_BEG   = 25'b1 << 13,
      S_N_RD    = 25'b1 << 14,
      S_N_VRD   = 25'b1 << 15,
      S_N_EV    = 25'b1 << 16,
      S_SO_RD   = 25'b1 << 17,
      S_SO_X    = 25'b1 << 18,
      S_SO_CMP  = 25'b1 << 19,
      S_SO_SH   = 25'b1 << 20,
      S_SO_PUT  = 25'b1 << 21,
      S_P_RD    = 25'b1 << 22,
      S_P_WR    = 25'b1 << 23,
      S_RESP    = 25'b1 << 24
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd      = rcm_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  rcm_pkg::OP_ROW: cmd = rcm_pkg::CMD_LOAD_ROW;
                  rcm_pkg::OP_COL: cmd = rcm_pkg::CMD_LOAD_COL;
                  rcm_pkg::OP_READ: begin
                     cmd = rcm_pkg::CMD_READ; state_in = S_RD_WAIT;
                  end
                  rcm_pkg::OP_RUN: begin
                     if (stat.bad_init) begin
                        cmd = rcm_pkg::CMD_END_BAD; state_in = S_RESP;
                     end else begin
                        cmd = rcm_pkg::CMD_RUN_START; state_in = S_RV_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd = rcm_pkg::CMD_READ_DONE; state_in = S_RESP;
         end
         S_RV_RD: begin
            if (stat.i_done) begin
               cmd = rcm_pkg::CMD_CK_START; state_in = S_CK_RD;
            end else begin
               cmd = rcm_pkg::CMD_RV_RD; state_in = S_RV_EV;
            end
         end
         S_RV_EV: begin
            if (stat.row_bad) begin
               cmd = rcm_pkg::CMD_END_BAD; state_in = S_RESP;
            end else begin
               cmd = rcm_pkg::CMD_RV_EV; state_in = S_RV_RD;
            end
         end
         S_CK_RD: begin
            if (stat.k_at_prev) begin
               cmd = rcm_pkg::CMD_W_INIT; state_in = S_S_INIT;
            end else begin
               cmd = rcm_pkg::CMD_K_RD; state_in = S_CK_EV;
            end
         end
         S_CK_EV: begin
            if (stat.col_bad) begin
               cmd = rcm_pkg::CMD_END_BAD; state_in = S_RESP;
            end else begin
               cmd = rcm_pkg::CMD_K_INC; state_in = S_CK_RD;
            end
         end
         S_S_INIT: begin
            cmd = rcm_pkg::CMD_S_INIT; state_in = S_S_RD;
         end
         S_S_RD: begin
            if (stat.i_done) begin
               state_in = S_S_END;
            end else begin
               cmd = rcm_pkg::CMD_S_RD; state_in = S_S_EV;
            end
         end
         S_S_EV: begin
            cmd = rcm_pkg::CMD_S_EV; state_in = S_S_RD;
         end
         S_S_END: begin
            cmd = rcm_pkg::CMD_S_END; state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            if (!stat.q_empty) begin
               cmd = rcm_pkg::CMD_Q_RD; state_in = S_Q_POP;
            end else if (stat.fill_zero) begin
               cmd = rcm_pkg::CMD_END_OK; state_in = S_RESP;
            end else begin
               state_in = S_S_INIT;
            end
         end
         S_Q_POP: begin
            cmd = rcm_pkg::CMD_Q_POP; state_in = S_Q_END;
         end
         S_Q_END: begin
            cmd = rcm_pkg::CMD_Q_END; state_in = S_Q_BEG;
         end
         S_Q_BEG: begin
            cmd = rcm_pkg::CMD_Q_BEG; state_in = S_N_RD;
         end
         S_N_RD: begin
            if (stat.k_at_end) begin
               cmd = rcm_pkg::CMD_A_ONE; state_in = S_SO_RD;
            end else begin
               cmd = rcm_pkg::CMD_K_RD; state_in = S_N_VRD;
            end
         end
         S_N_VRD: begin
            cmd = rcm_pkg::CMD_N_VRD; state_in = S_N_EV;
         end
         S_N_EV: begin
            if (!stat.vis_set && stat.cnt_full) begin
               cmd = rcm_pkg::CMD_END_OVF; state_in = S_RESP;
            end else begin
               cmd = rcm_pkg::CMD_N_EV; state_in = S_N_RD;
            end
         end
         S_SO_RD: begin
            if (stat.a_done) begin
               cmd = rcm_pkg::CMD_A_ZERO; state_in = S_P_RD;
            end else begin
               cmd = rcm_pkg::CMD_A_RD; state_in = S_SO_X;
            end
         end
         S_SO_X: begin
            cmd = rcm_pkg::CMD_SO_X; state_in = S_SO_CMP;
         end
         S_SO_CMP: begin
            if (stat.b_zero) begin
               state_in = S_SO_PUT;
            end else begin
               cmd = rcm_pkg::CMD_SO_CMP; state_in = S_SO_SH;
            end
         end
         S_SO_SH: begin
            if (stat.shift) begin
               cmd = rcm_pkg::CMD_SO_SH; state_in = S_SO_CMP;
            end else begin
               state_in = S_SO_PUT;
            end
         end
         S_SO_PUT: begin
            cmd = rcm_pkg::CMD_SO_PUT; state_in = S_SO_RD;
         end
         S_P_RD: begin
            if (stat.push_done) begin
               state_in = S_Q_CHK;
            end else begin
               cmd = rcm_pkg::CMD_A_RD; state_in = S_P_WR;
            end
         end
         S_P_WR: begin
            cmd = rcm_pkg::CMD_P_WR; state_in = S_P_RD;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[src/rcm_graph_ordering.sv]
// Top level of the reverse Cuthill-McKee graph ordering block.
//
// req_ch carries words {operation, value}; rsp_ch returns {node, status}.
// Row end loads (0) and column loads (1) are taken one per cycle, give no
// result and fill the stores in sequence; the first load after a run starts
// a new pattern. A read (3) passes through the S_RD_WAIT state, which takes
// the stored node, before rsp_ch.valid rises. A run (2) answers with status
// only. Its length is set by the memory walk: the row check, the column check,
// a start scan per component, plus work per node, per column entry, per queued
// neighbour and per sort shift. One word is in work at a time: req_ch.ready
// is low from the acceptance of a read or run until its response is taken,
// and a response holds on rsp_ch for as long as the receiver stalls.
// node_count sits at csr address 0 (reset value 1); write it only while idle.
// Reset is synchronous: the sequencer goes idle, load counts and run status
// clear. Stores need no clearing pass; a read before any run reports a bad
// request.
module rcm_graph_ordering #(
   parameter int MAX_NODES    = rcm_pkg::DEF_MAX_NODES,
   parameter int MAX_NONZEROS = rcm_pkg::DEF_MAX_NONZEROS,
   parameter int MAX_DEGREE   = rcm_pkg::DEF_MAX_DEGREE
) (
   input  logic                         clock,
   input  logic                         reset,
   rcm_req_if.sink                      req_ch,
   rcm_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rcm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rcm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rcm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   logic [rcm_pkg::CFG_W-1:0] node_count_ff, node_count_in;
   rcm_pkg::dp_status_type    stat;
   rcm_pkg::cmd_type          cmd;
   rcm_pkg::status_type       rsp_status;
   logic                      csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[rcm_pkg::CSR_AW-1:2] == '0;
   assign csr_prdata = csr_hit ? rcm_pkg::CSR_DW'(node_count_ff) : '0;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit)
         node_count_in = csr_pwdata[rcm_pkg::CFG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= rcm_pkg::CFG_W'(1);
      else       node_count_ff <= node_count_in;
   end

   rcm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (rcm_pkg::op_type'(req_ch.operation)),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcm_datapath #(
      .MAX_NODES    (MAX_NODES),
      .MAX_NONZEROS (MAX_NONZEROS),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_ch.value),
      .node_count (node_count_ff),
      .stat       (stat),
      .rsp_node   (rsp_ch.node),
      .rsp_status (rsp_status)
   );

   assign rsp_ch.status = rsp_status;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while a response is pending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready &&
       (req_ch.operation == rcm_pkg::OP_RUN || req_ch.operation == rcm_pkg::OP_READ))
      |=> !req_ch.ready)
      else $error("ready stayed high after a run or read word");

   a_err_node: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != rcm_pkg::ST_OK) |-> rsp_ch.node == '0)
      else $error("error response carries a nonzero node");

endmodule

[tb/tb.sv]
// Self-checking testbench of the RCM graph ordering block: directed and random patterns.
`timescale 1ns / 1ps
module tb;

   localparam int MAXN        = rcm_pkg::DEF_MAX_NODES;
   localparam int MAXNZ       = rcm_pkg::DEF_MAX_NONZEROS;
   localparam int MAXDEG      = rcm_pkg::DEF_MAX_DEGREE;
   localparam int STALL_LIMIT = 400000;
   localparam int WORD_TOTAL  = 1850;

   typedef struct packed {
      logic [rcm_pkg::NODE_W-1:0] node;
      rcm_pkg::status_type        status;
   } answer_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [rcm_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [rcm_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [rcm_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;

   rcm_req_if req ();
   rcm_rsp_if rsp ();

   rcm_graph_ordering u_top (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // ordering model state
   logic [rcm_pkg::VALUE_W-1:0] row_end_mem [MAXN];
   logic [rcm_pkg::VALUE_W-1:0] col_mem [MAXNZ];
   logic [rcm_pkg::NODE_W-1:0]  order_mem [MAXN];
   int                          deg [MAXN];
   bit                          seen [MAXN];
   int                          wq [MAXN];
   int                          nb [MAXDEG];
   int                          rows_ld = 0, cols_ld = 0, ord_cnt = 0, cfg_nodes = 1;
   rcm_pkg::status_type         run_st = rcm_pkg::ST_OK;
   bit                          reload = 1'b0;

   answer_type pending_answers[$];
   int         fails = 0;
   int         words_sent = 0;
   int         idle_cycles = 0;
   bit         quiet = 1'b0;
   bit         hold_rsp = 1'b0;

   function automatic rcm_pkg::status_type order_nodes();
      int n, prev, e, fill, placed, start, best, u, cnt, v, x, b, lo, qh, qt;
      bit found;
      n = cfg_nodes;
      if (n == 0 || n > MAXN || rows_ld < n) return rcm_pkg::ST_BAD;
      prev = 0;
      for (int i = 0; i < n; i++) begin
         e = row_end_mem[i];
         if (e < prev || e > cols_ld) return rcm_pkg::ST_BAD;
         deg[i] = e - prev;
         prev = e;
      end
      for (int k = 0; k < prev; k++)
         if (col_mem[k] >= n) return rcm_pkg::ST_BAD;
      for (int i = 0; i < MAXN; i++) seen[i] = 1'b0;
      qh = 0; qt = 0; fill = n; placed = 0; best = 0; start = 0;
      while (placed < n) begin
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!seen[i] && (!found || deg[i] < best)) begin
               best = deg[i]; start = i; found = 1'b1;
            end
         end
         if (!found) break;
         seen[start] = 1'b1;
         wq[qt++] = start;
         while (qh < qt) begin
            u = wq[qh++];
            cnt = 0;
            fill--;
            order_mem[fill] = u;
            placed++;
            lo = (u == 0) ? 0 : row_end_mem[u-1];
            for (int k = lo; k < row_end_mem[u]; k++) begin
               v = col_mem[k];
               if (!seen[v]) begin
                  if (cnt >= MAXDEG) return rcm_pkg::ST_OVF;
                  nb[cnt++] = v;
                  seen[v] = 1'b1;
               end
            end
            for (int a = 1; a < cnt; a++) begin
               x = nb[a];
               b = a;
               while (b > 0 && deg[nb[b-1]] > deg[x]) begin
                  nb[b] = nb[b-1];
                  b--;
               end
               nb[b] = x;
            end
            for (int a = 0; a < cnt && qt < MAXN; a++) wq[qt++] = nb[a];
         end
      end
      return rcm_pkg::ST_OK;
   endfunction

   task automatic note_word(rcm_pkg::op_type op, logic [rcm_pkg::VALUE_W-1:0] val);
      case (op)
         rcm_pkg::OP_ROW, rcm_pkg::OP_COL: begin
            if (reload) begin
               rows_ld = 0; cols_ld = 0; reload = 1'b0;
            end
            if (op == rcm_pkg::OP_ROW) begin
               if (rows_ld < MAXN) row_end_mem[rows_ld++] = val;
            end else if (cols_ld < MAXNZ) begin
               col_mem[cols_ld++] = val;
            end
         end
         rcm_pkg::OP_RUN: begin
            run_st = order_nodes();
            ord_cnt = cfg_nodes;
            reload = 1'b1;
            pending_answers.push_back(answer_type'{node: '0, status: run_st});
         end
         default: begin
            if (run_st != rcm_pkg::ST_OK)
               pending_answers.push_back(answer_type'{node: '0, status: run_st});
            else if (val >= ord_cnt || val >= MAXN)
               pending_answers.push_back(answer_type'{node: '0, status: rcm_pkg::ST_BAD});
            else
               pending_answers.push_back(answer_type'{node: order_mem[val],
                                                      status: rcm_pkg::ST_OK});
         end
      endcase
   endtask

   // called at a rising edge; returns at the edge that took the word
   task automatic send_word(rcm_pkg::op_type op, int val);
      bit hit;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.value     <= val[rcm_pkg::VALUE_W-1:0];
      do begin
         @(negedge clock);
         hit = req.valid && req.ready;
         @(posedge clock);
      end while (!hit);
      note_word(op, val[rcm_pkg::VALUE_W-1:0]);
      words_sent++;
   endtask

   task automatic idle_wait();
      req.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_nodes(int v);
      idle_wait();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= v;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cfg_nodes = v & 'h7FF;
   endtask

   task automatic load_pattern(ref int ends[$], ref int cols[$]);
      foreach (ends[i]) send_word(rcm_pkg::OP_ROW, ends[i]);
      foreach (cols[i]) send_word(rcm_pkg::OP_COL, cols[i]);
   endtask

   task automatic random_graph(int n, int maxd, ref int ends[$], ref int cols[$]);
      int d;
      ends.delete();
      cols.delete();
      for (int i = 0; i < n; i++) begin
         d = $urandom_range(0, maxd);
         repeat (d) cols.push_back($urandom_range(0, n - 1));
         ends.push_back(cols.size());
      end
   endtask

   task automatic read_all(int n);
      for (int p = 0; p <= n; p++) send_word(rcm_pkg::OP_READ, p);
   endtask

   task automatic test_before_run();
      send_word(rcm_pkg::OP_READ, 0);
      send_word(rcm_pkg::OP_READ, 16383);
      send_word(rcm_pkg::OP_RUN, 0);
      send_word(rcm_pkg::OP_READ, 0);
   endtask

   task automatic test_single_node();
      write_nodes(1);
      send_word(rcm_pkg::OP_ROW, 0);
      send_word(rcm_pkg::OP_RUN, 0);
      read_all(1);
   endtask

   // two components, tie on degree, repeated and self columns, isolated node
   task automatic test_small_graph();
      int ends[$];
      int cols[$];
      cols = '{2, 1, 0, 3, 0, 3, 1, 2, 3, 4, 1, 3, 5, 4};
      ends = '{2, 4, 6, 11, 13, 14, 14};
      write_nodes(7);
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      read_all(7);
   endtask

   task automatic test_bad_structure();
      int ends[$];
      int cols[$];
      write_nodes(0);
      send_word(rcm_pkg::OP_RUN, 0);
      send_word(rcm_pkg::OP_READ, 0);
      write_nodes(2047);
      send_word(rcm_pkg::OP_RUN, 0);
      write_nodes(3);
      ends = '{2, 1, 3}; cols = '{1, 2, 0};
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      ends = '{1, 2, 16383};
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      ends = '{1, 2, 3}; cols = '{1, 3, 0};
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      send_word(rcm_pkg::OP_READ, 1);
      ends = '{1, 2}; cols = '{1, 0};
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
   endtask

   task automatic star_run(int n);
      int ends[$];
      int cols[$];
      for (int i = 1; i < n; i++) cols.push_back(i);
      ends.push_back(n - 1);
      for (int i = 1; i < n; i++) begin
         cols.push_back(0);
         ends.push_back(cols.size());
      end
      write_nodes(n);
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      send_word(rcm_pkg::OP_READ, 0);
      send_word(rcm_pkg::OP_READ, n - 1);
   endtask

   task automatic test_neighbour_overflow();
      star_run(MAXDEG + 3);
      star_run(MAXDEG + 2);
   endtask

   task automatic test_backpressure();
      int ends[$];
      int cols[$];
      write_nodes(12);
      random_graph(12, 3, ends, cols);
      load_pattern(ends, cols);
      send_word(rcm_pkg::OP_RUN, 0);
      hold_rsp = 1'b1;
      repeat (16) send_word(rcm_pkg::OP_READ, $urandom_range(0, 12));
   endtask

   task automatic test_random();
      int ends[$];
      int cols[$];
      int n, r, maxd;
      n = 8;
      while (words_sent < WORD_TOTAL) begin
         if (words_sent > WORD_TOTAL - 300) quiet = 1'b1;
         if ($urandom_range(0, 5) != 0) begin
            if (words_sent < WORD_TOTAL - 450 && $urandom_range(0, 11) == 0)
               n = $urandom_range(25, 100);
            else
               n = $urandom_range(1, 24);
            write_nodes(n);
         end
         maxd = (n <= 24 && $urandom_range(0, 3) == 0) ? 8 : 3;
         random_graph(n, maxd, ends, cols);
         case ($urandom_range(0, 11))
            0: if (cols.size() != 0)
                  cols[$urandom_range(0, cols.size() - 1)] = $urandom_range(n, 16383);
            1: ends[0] = cols.size() + 1;
            2: void'(ends.pop_back());
            3: ends[$urandom_range(0, n - 1)] = $urandom_range(0, 16383);
            default: ;
         endcase
         load_pattern(ends, cols);
         send_word(rcm_pkg::OP_RUN, 0);
         r = $urandom_range(1, n < 8 ? n + 1 : 8);
         repeat (r) begin
            if ($urandom_range(0, 7) == 0)
               send_word(rcm_pkg::OP_READ, $urandom_range(0, 16383));
            else
               send_word(rcm_pkg::OP_READ, $urandom_range(0, n));
         end
      end
   endtask

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected word: node %0d status %0d", rsp.node, rsp.status);
            fails++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp.node !== want.node) begin
               $error("node: expected %0d actual %0d", want.node, rsp.node);
               fails++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp.status);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("rcm_graph_ordering verification failed");
            $finish;
         end
      end
   end

   initial begin
      req.valid     = 1'b0;
      req.operation = rcm_pkg::OP_ROW;
      req.value     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_run();
      test_single_node();
      test_small_graph();
      test_bad_structure();
      test_neighbour_overflow();
      test_backpressure();
      test_random();
      quiet = 1'b1;
      idle_wait();
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("rcm_graph_ordering verification clean");
      end else begin
         $display("rcm_graph_ordering verification failed");
      end
      $finish;
   end

endmodule
